### src/psu_pkg.sv
// Shared types and constants for the pixel similarity unit.
package psu_pkg;

	typedef enum logic [1:0] {
		FMT_RGB565 = 2'd0,
		FMT_RGB555 = 2'd1,
		FMT_RGB888 = 2'd2,
		FMT_YUY2   = 2'd3
	} fmt_t;

	typedef enum logic {
		OP_DIFF = 1'b0,
		OP_DIST = 1'b1
	} op_t;

	localparam int PIXEL_W = 32;
	localparam int DIST_W  = 12;
	localparam int FMT_W   = 2;

	// Limits for the RGB formats, applied to the approximate Y, U, V.
	localparam int Y_LIM_RGB = 192;
	localparam int U_LIM_RGB = 28;
	localparam int V_LIM_RGB = 48;

	// Limits for YUY2 byte differences.
	localparam int Y_LIM_YUV = 48;
	localparam int U_LIM_YUV = 7;
	localparam int V_LIM_YUV = 6;

	// Early equality mask for RGB888: top five bits of each channel.
	localparam logic [23:0] RGB888_EQ_MASK = 24'hF8F8F8;

endpackage

### src/psu_in_if.sv
// Input channel: one pixel pair and the operation.
interface psu_in_if
	import psu_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                op;
	logic [PIXEL_W-1:0]  pixel_a;
	logic [PIXEL_W-1:0]  pixel_b;

	modport source (output valid, op, pixel_a, pixel_b, input ready);
	modport sink   (input valid, op, pixel_a, pixel_b, output ready);
endinterface

### src/psu_out_if.sv
// Result channel: difference flag and weighted distance.
interface psu_out_if
	import psu_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               differs;
	logic [DIST_W-1:0]  distance;

	modport source (output valid, differs, distance, input ready);
	modport sink   (input valid, differs, distance, output ready);
endinterface

### src/psu_cfg_if.sv
// Configuration write channel for the pixel format register.
interface psu_cfg_if
	import psu_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [FMT_W-1:0]  data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

### src/pixel_similarity_unit.sv
// Top level of the pixel similarity unit: three-stage compare pipeline.
//
//  channel  dir  payload                       transaction when
//  in_ch    in   op, pixel_a[31:0], pixel_b    valid && ready
//  out_ch   out  differs, distance[11:0]       valid && ready
//  cfg      in   data[1:0] (pixel_format)      valid && ready (ready always high)
//
// One pixel pair enters per cycle unless a stalled output has filled the pipeline;
// each result passes through the three pipeline registers: channel differences,
// Y/U/V sums with magnitudes, then limit tests and weighted sum.
// arst_n clears all stage valid bits and sets the format to rgb565.
// A stalled output holds its result; earlier stages keep filling until full.
module pixel_similarity_unit
	import psu_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	psu_in_if.sink     in_ch,
	psu_out_if.source  out_ch,
	psu_cfg_if.sink    cfg
);

	fmt_t fmt_q;

	// Stage 1: channel differences
	logic              v_s1;
	logic              op_s1;
	fmt_t              fmt_s1;
	logic              same_s1;
	logic signed [8:0] dr_s1, dg_s1, db_s1;

	// Stage 2: Y/U/V and magnitudes
	logic               v_s2;
	logic               op_s2;
	fmt_t               fmt_s2;
	logic               same_s2;
	logic signed [10:0] y_s2;
	logic signed [9:0]  u_s2;
	logic signed [10:0] w_s2;
	logic [7:0]         ar_s2, ag_s2, ab_s2;

	// Stage 3: result register
	logic              v_s3;
	fmt_t              fmt_s3;
	logic              differs_s3;
	logic [DIST_W-1:0] distance_s3;

	logic rdy_s1, rdy_s2, rdy_s3;

	assign rdy_s3 = !v_s3 || out_ch.ready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign in_ch.ready = rdy_s1;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_RGB565;
		end else if (cfg.valid) begin
			fmt_q <= fmt_t'(cfg.data);
		end
	end

	// Unpack channels to 8-bit scale; YUY2 puts V, U, Y in the r, g, b slots.
	logic [7:0] ra, ga, ba, rb, gb, bb;
	logic       same_in;

	always_comb begin
		ra = '0; ga = '0; ba = '0;
		rb = '0; gb = '0; bb = '0;
		same_in = 1'b0;
		unique case (fmt_q)
			FMT_RGB565: begin
				ra = {in_ch.pixel_a[15:11], 3'b000};
				ga = {in_ch.pixel_a[10:5], 2'b00};
				ba = {in_ch.pixel_a[4:0], 3'b000};
				rb = {in_ch.pixel_b[15:11], 3'b000};
				gb = {in_ch.pixel_b[10:5], 2'b00};
				bb = {in_ch.pixel_b[4:0], 3'b000};
				same_in = (in_ch.pixel_a[15:0] == in_ch.pixel_b[15:0]);
			end
			FMT_RGB555: begin
				ra = {in_ch.pixel_a[14:10], 3'b000};
				ga = {in_ch.pixel_a[9:5], 3'b000};
				ba = {in_ch.pixel_a[4:0], 3'b000};
				rb = {in_ch.pixel_b[14:10], 3'b000};
				gb = {in_ch.pixel_b[9:5], 3'b000};
				bb = {in_ch.pixel_b[4:0], 3'b000};
				same_in = (in_ch.pixel_a[15:0] == in_ch.pixel_b[15:0]);
			end
			FMT_RGB888: begin
				ra = in_ch.pixel_a[23:16];
				ga = in_ch.pixel_a[15:8];
				ba = in_ch.pixel_a[7:0];
				rb = in_ch.pixel_b[23:16];
				gb = in_ch.pixel_b[15:8];
				bb = in_ch.pixel_b[7:0];
				same_in = ((in_ch.pixel_a[23:0] & RGB888_EQ_MASK) ==
				           (in_ch.pixel_b[23:0] & RGB888_EQ_MASK));
			end
			FMT_YUY2: begin
				ra = in_ch.pixel_a[31:24];
				ga = in_ch.pixel_a[15:8];
				ba = in_ch.pixel_a[7:0];
				rb = in_ch.pixel_b[31:24];
				gb = in_ch.pixel_b[15:8];
				bb = in_ch.pixel_b[7:0];
				same_in = (in_ch.pixel_a == in_ch.pixel_b);
			end
			default: begin
				same_in = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_ch.valid) begin
			op_s1   <= in_ch.op;
			fmt_s1  <= fmt_q;
			same_s1 <= same_in;
			dr_s1   <= $signed({1'b0, ra}) - $signed({1'b0, rb});
			dg_s1   <= $signed({1'b0, ga}) - $signed({1'b0, gb});
			db_s1   <= $signed({1'b0, ba}) - $signed({1'b0, bb});
		end
	end

	// Magnitude of a channel difference; the range stops at 255.
	function automatic logic [7:0] mag9(input logic signed [8:0] x);
		logic [8:0] n;
		n = x[8] ? 9'(-x) : 9'(x);
		return n[7:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			op_s2   <= op_s1;
			fmt_s2  <= fmt_s1;
			same_s2 <= same_s1;
			y_s2    <= 11'(dr_s1) + 11'(dg_s1) + 11'(db_s1);
			u_s2    <= 10'(dr_s1) - 10'(db_s1);
			w_s2    <= (11'(dg_s1) <<< 1) - 11'(dr_s1) - 11'(db_s1);
			ar_s2   <= mag9(dr_s1);
			ag_s2   <= mag9(dg_s1);
			ab_s2   <= mag9(db_s1);
		end
	end

	// Limit tests and weighted distance.
	logic              flag_c;
	logic [DIST_W-1:0] dist_c;

	always_comb begin
		flag_c = 1'b0;
		dist_c = '0;
		if (!same_s2) begin
			if (fmt_s2 == FMT_YUY2) begin
				flag_c = (ab_s2 > 8'(Y_LIM_YUV)) || (ag_s2 > 8'(U_LIM_YUV)) ||
				         (ar_s2 > 8'(V_LIM_YUV));
				dist_c = DIST_W'(ab_s2);
			end else begin
				flag_c = (y_s2 > 11'(Y_LIM_RGB)) || (y_s2 < -11'(Y_LIM_RGB)) ||
				         (u_s2 > 10'(U_LIM_RGB)) || (u_s2 < -10'(U_LIM_RGB)) ||
				         (w_s2 > 11'(V_LIM_RGB)) || (w_s2 < -11'(V_LIM_RGB));
				dist_c = DIST_W'({ar_s2, 1'b0}) + DIST_W'(ar_s2) +
				         DIST_W'({ag_s2, 2'b00}) + DIST_W'({ab_s2, 1'b0});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			fmt_s3      <= fmt_s2;
			differs_s3  <= (op_s2 == OP_DIFF) ? flag_c : 1'b0;
			distance_s3 <= (op_s2 == OP_DIST) ? dist_c : '0;
		end
	end

	assign out_ch.valid    = v_s3;
	assign out_ch.differs  = differs_s3;
	assign out_ch.distance = distance_s3;

	// Only the field chosen by op may be nonzero.
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> !(differs_s3 && (distance_s3 != '0)))
		else $error("both result fields nonzero");

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (distance_s3 <= DIST_W'(2295)))
		else $error("distance out of range");

	a_yuy2_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && fmt_s3 == FMT_YUY2) |-> (distance_s3[DIST_W-1:8] == '0))
		else $error("yuy2 distance exceeds one byte");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> v_s1)
		else $error("accepted transaction lost at stage 1");

endmodule
